// ===== sv/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// types and constants for the gregorian date adder: beat structs, calendar
// limits and the month length table
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned CYC_W   = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [CYC_W-1:0]   YEAR_CYC  = 9'd400;
  localparam logic [CYC_W-1:0]   CENT_1    = 9'd100;
  localparam logic [CYC_W-1:0]   CENT_2    = 9'd200;
  localparam logic [CYC_W-1:0]   CENT_3    = 9'd300;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] days_to_add;
  } gdad_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               year_overflow;
  } gdad_out_t;

  // month must already be in 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    begin
      case (m)
        4'd2:                    d = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
        default:                 d = 5'd31;
      endcase
      return d;
    end
  endfunction

endpackage

// ===== sv/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// clamps a start date, adds a day count and walks forward a month at a time
// under the gregorian leap rule, saturating at 31 december 9999
// ----------------------------------------------------------------------------
//  channel   signals                       beat
//  in        in_valid in_ready in_data     start date and day count
//  out       out_valid out_ready out_data  result date and overflow flag
//
//  one shared 18-bit subtractor does the reductions: first the year is reduced
//  mod 400, then the day is clamped and the day count added, then one month is
//  taken off per cycle until the day fits in its month or the year passes 9999
//  in_ready is low from acceptance until the result is loaded into out_data
//  reset clears the sequencer and out_valid; a stalled output holds the block
//  in its final state until the pending beat is taken
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gdad_pkg::gdad_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gdad_pkg::gdad_out_t out_data
);
  import gdad_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MOD    = 3'd1;
  localparam logic [2:0] ST_DAY    = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]         state;
  logic [SUM_W-1:0]   dsum;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [YEAR_W-1:0]  rem;
  logic [CYC_W-1:0]   yr400;
  logic [COUNT_W-1:0] count;
  logic               ovf;

  logic [MONTH_W-1:0] m_clamp;
  logic [YEAR_W-1:0]  y_clamp;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [SUM_W-1:0]   sub_a;
  logic [SUM_W-1:0]   sub_b;
  logic [SUM_W:0]     diff;
  logic               borrow;
  logic [DAY_W-1:0]   d_clamp;

  always_comb begin
    if (in_data.start_month == '0) begin
      m_clamp = MONTH_JAN;
    end else if (in_data.start_month > MONTH_DEC) begin
      m_clamp = MONTH_DEC;
    end else begin
      m_clamp = in_data.start_month;
    end
    y_clamp = (in_data.start_year == '0) ? {{(YEAR_W-1){1'b0}}, 1'b1} : in_data.start_year;
  end

  // leap: divisible by 4, and not a century unless the 400-year phase is zero
  assign leap = (year[1:0] == 2'b00) &&
                !(yr400 == CENT_1 || yr400 == CENT_2 || yr400 == CENT_3);
  assign len  = month_days(month, leap);

  // shared subtractor
  always_comb begin
    if (state == ST_MOD) begin
      sub_a = {{(SUM_W-YEAR_W){1'b0}}, rem};
      sub_b = {{(SUM_W-CYC_W){1'b0}}, YEAR_CYC};
    end else begin
      sub_a = dsum;
      sub_b = {{(SUM_W-DAY_W){1'b0}}, len};
    end
    diff   = {1'b0, sub_a} - {1'b0, sub_b};
    borrow = diff[SUM_W];
  end

  always_comb begin
    if (dsum[DAY_W-1:0] == '0) begin
      d_clamp = {{(DAY_W-1){1'b0}}, 1'b1};
    end else if (dsum[DAY_W-1:0] > len) begin
      d_clamp = len;
    end else begin
      d_clamp = dsum[DAY_W-1:0];
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dsum  <= {{(SUM_W-DAY_W){1'b0}}, in_data.start_day};
            month <= m_clamp;
            year  <= y_clamp;
            rem   <= y_clamp;
            count <= in_data.days_to_add;
            ovf   <= (y_clamp > YEAR_MAX);
            state <= (y_clamp > YEAR_MAX) ? ST_FINISH : ST_MOD;
          end
        end
        ST_MOD: begin
          if (!borrow) begin
            rem <= diff[YEAR_W-1:0];
          end else begin
            yr400 <= rem[CYC_W-1:0];
            state <= ST_DAY;
          end
        end
        ST_DAY: begin
          dsum  <= {{(SUM_W-DAY_W){1'b0}}, d_clamp} + {{(SUM_W-COUNT_W){1'b0}}, count};
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (!borrow && diff[SUM_W-1:0] != '0) begin
            dsum <= diff[SUM_W-1:0];
            if (month == MONTH_DEC) begin
              month <= MONTH_JAN;
              year  <= year + 1'b1;
              yr400 <= (yr400 == YEAR_CYC - 1'b1) ? '0 : yr400 + 1'b1;
              if (year == YEAR_MAX) begin
                ovf   <= 1'b1;
                state <= ST_FINISH;
              end
            end else begin
              month <= month + 1'b1;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || out_ready)) begin
      if (ovf) begin
        out_data.result_day   <= DAY_LAST;
        out_data.result_month <= MONTH_DEC;
        out_data.result_year  <= YEAR_MAX;
      end else begin
        out_data.result_day   <= dsum[DAY_W-1:0];
        out_data.result_month <= month;
        out_data.result_year  <= year;
      end
      out_data.year_overflow <= ovf;
    end
  end

  // year phase tracks the year's low bits during the walk
  a_phase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (yr400 < YEAR_CYC && yr400[1:0] == year[1:0]))
    else $error("year phase out of step");

  a_month: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_month >= MONTH_JAN &&
                   out_data.result_month <= MONTH_DEC &&
                   out_data.result_day != '0))
    else $error("result date out of range");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.year_overflow) |->
      (out_data.result_day == DAY_LAST && out_data.result_month == MONTH_DEC &&
       out_data.result_year == YEAR_MAX))
    else $error("overflow result not saturated");

  a_year: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_year != '0 && out_data.result_year <= YEAR_MAX))
    else $error("result year out of range");

endmodule

// ===== tb/sv/gdad_date_check.sv =====
// ----------------------------------------------------------------------------
// gdad_date_check
// watches both channels of the gregorian date adder, predicts the result date
// of every accepted input beat and compares each output beat field by field
// with the oldest prediction; counts failures for the testbench top
// ----------------------------------------------------------------------------
module gdad_date_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  gdad_pkg::gdad_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  gdad_pkg::gdad_out_t out_data,
  output int unsigned         fail_count,
  output int unsigned         dates_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int unsigned COMMON_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  gdad_out_t expected_dates [$];

  function automatic bit is_leap_year(input int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned len;
    len = COMMON_LEN[m];
    if (m == MONTH_FEB && is_leap_year(y)) len++;
    return len;
  endfunction

  function automatic gdad_out_t advance_date(input gdad_in_t beat);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    bit          ovf;
    gdad_out_t   res;
    d   = 32'(beat.start_day);
    m   = 32'(beat.start_month);
    y   = 32'(beat.start_year);
    ovf = 1'b0;
    if (m < MONTH_JAN) m = MONTH_JAN;
    if (m > MONTH_DEC) m = MONTH_DEC;
    if (y < 1) y = 1;
    if (d < 1) d = 1;
    if (d > month_length(m, y)) d = month_length(m, y);
    if (y > YEAR_MAX) begin
      ovf = 1'b1;
    end else begin
      d += 32'(beat.days_to_add);
      while (!ovf && d > month_length(m, y)) begin
        d -= month_length(m, y);
        m++;
        if (m > MONTH_DEC) begin
          m = MONTH_JAN;
          y++;
          if (y > YEAR_MAX) ovf = 1'b1;
        end
      end
    end
    if (ovf) begin
      d = DAY_LAST;
      m = MONTH_DEC;
      y = YEAR_MAX;
    end
    res.result_day    = DAY_W'(d);
    res.result_month  = MONTH_W'(m);
    res.result_year   = YEAR_W'(y);
    res.year_overflow = ovf;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input logic [YEAR_W-1:0] got);
    if (got !== YEAR_W'(want)) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count    = 0;
    dates_pending = 0;
  end

  always @(posedge clk) begin
    gdad_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) expected_dates.push_back(advance_date(in_data));
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %0d-%0d-%0d ovf %0b",
                   $time, out_data.result_year, out_data.result_month,
                   out_data.result_day, out_data.year_overflow);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("result_day", 32'(want.result_day), YEAR_W'(out_data.result_day));
          check_field("result_month", 32'(want.result_month),
                      YEAR_W'(out_data.result_month));
          check_field("result_year", 32'(want.result_year), out_data.result_year);
          check_field("year_overflow", 32'(want.year_overflow),
                      YEAR_W'(out_data.year_overflow));
        end
      end
      dates_pending = expected_dates.size();
    end
  end

endmodule

// ===== tb/sv/tb_gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days
// drives clamped and unclamped start dates with day counts into the gregorian
// date adder under random idling on both channels, with a long output stall
// and a drain pause; the date check module predicts and compares every beat
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days;
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned RANDOM_BEATS = 250;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  gdad_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  gdad_out_t   out_data;
  int unsigned fail_count;
  int unsigned dates_pending;

  gregorian_date_add_days DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gdad_date_check date_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .dates_pending (dates_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic gdad_in_t date_beat(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input int unsigned n);
    gdad_in_t beat;
    beat.start_day   = DAY_W'(d);
    beat.start_month = MONTH_W'(m);
    beat.start_year  = YEAR_W'(y);
    beat.days_to_add = COUNT_W'(n);
    return beat;
  endfunction

  function automatic gdad_in_t random_date();
    gdad_in_t    beat;
    int unsigned r;
    beat.start_day   = DAY_W'($urandom_range(0, 31));
    beat.start_month = MONTH_W'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 75)      beat.start_year = YEAR_W'($urandom_range(1, 9999));
    else if (r < 85) beat.start_year = YEAR_W'($urandom_range(0, 16383));
    else             beat.start_year = YEAR_W'($urandom_range(9980, 9999));
    r = $urandom_range(0, 99);
    if (r < 45)      beat.days_to_add = COUNT_W'($urandom_range(0, 65535));
    else if (r < 75) beat.days_to_add = COUNT_W'($urandom_range(0, 400));
    else             beat.days_to_add = COUNT_W'($urandom_range(0, 40));
    return beat;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_date(input gdad_in_t beat);
    int unsigned gap;
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (dates_pending != 0) @(negedge clk);
  endtask

  initial begin
    gdad_in_t directed [$];
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    directed = '{
      date_beat(0, 0, 0, 0),
      date_beat(1, 1, 1, 3),
      date_beat(31, 15, 9999, 0),
      date_beat(31, 2, 2000, 0),
      date_beat(30, 2, 1900, 0),
      date_beat(29, 2, 2024, 0),
      date_beat(29, 2, 2023, 0),
      date_beat(31, 4, 2021, 0),
      date_beat(28, 2, 2100, 1),
      date_beat(28, 2, 2000, 1),
      date_beat(31, 12, 1999, 1),
      date_beat(5, 13, 5000, 100),
      date_beat(0, 12, 16383, 0),
      date_beat(10, 6, 10000, 65535),
      date_beat(31, 12, 9999, 1),
      date_beat(31, 12, 9998, 365),
      date_beat(31, 12, 9998, 366),
      date_beat(31, 1, 1, 65535),
      date_beat(0, 0, 9990, 65535),
      date_beat(31, 1, 2023, 28),
      date_beat(31, 1, 2024, 29),
      date_beat(17, 9, 1600, 65535)
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) send_date(directed[i]);
    wait_drained();
    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      send_date(random_date());
      if (i == RANDOM_BEATS / 2) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: long hold-off first so the block backs up, then random stalls
  initial begin
    int unsigned run;
    int unsigned gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
